FILE: rtl/mdk_pkg.sv
// ----------------------------------------------------------------------------
// mdk_pkg: shared types and constants for the md5 counter keystream block
// md5 round constants, rotate amounts, message word order and the queue entry
// ----------------------------------------------------------------------------
package mdk_pkg;

  localparam int unsigned DataW  = 64;
  localparam int unsigned CntW   = 5;
  localparam int unsigned NumRnd = 64;
  localparam int unsigned RndW   = 6;
  localparam int unsigned NumSeed = 4;
  localparam int unsigned IdxW   = 2;
  localparam int unsigned MaxBytes = 16;

  localparam logic [31:0] IvA = 32'h67452301;
  localparam logic [31:0] IvB = 32'hefcdab89;
  localparam logic [31:0] IvC = 32'h98badcfe;
  localparam logic [31:0] IvD = 32'h10325476;

  // request held between front and back
  typedef struct packed {
    logic [255:0]      counter;
    logic [DataW-1:0]  data_low;
    logic [DataW-1:0]  data_high;
    logic [4:0]        nbytes;
  } job_t;

  typedef struct packed {
    logic [DataW-1:0] out_low;
    logic [DataW-1:0] out_high;
  } res_t;

  function automatic logic [31:0] round_k(input logic [RndW-1:0] i);
    logic [31:0] k;
    case (i)
      6'd0: k = 32'hd76aa478; 6'd1: k = 32'he8c7b756; 6'd2: k = 32'h242070db;
      6'd3: k = 32'hc1bdceee; 6'd4: k = 32'hf57c0faf; 6'd5: k = 32'h4787c62a;
      6'd6: k = 32'ha8304613; 6'd7: k = 32'hfd469501; 6'd8: k = 32'h698098d8;
      6'd9: k = 32'h8b44f7af; 6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
      6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
      6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
      6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
      6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
      6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
      6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
      6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
      6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
      default: k = 32'heb86d391;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] round_rot(input logic [RndW-1:0] i);
    logic [4:0] r;
    case ({i[5:4], i[1:0]})
      4'b0000: r = 5'd7;  4'b0001: r = 5'd12; 4'b0010: r = 5'd17; 4'b0011: r = 5'd22;
      4'b0100: r = 5'd5;  4'b0101: r = 5'd9;  4'b0110: r = 5'd14; 4'b0111: r = 5'd20;
      4'b1000: r = 5'd4;  4'b1001: r = 5'd11; 4'b1010: r = 5'd16; 4'b1011: r = 5'd23;
      4'b1100: r = 5'd6;  4'b1101: r = 5'd10; 4'b1110: r = 5'd15;
      default: r = 5'd21;
    endcase
    return r;
  endfunction

  // message word index per round
  function automatic logic [3:0] round_g(input logic [RndW-1:0] i);
    logic [3:0] g;
    case (i[5:4])
      2'd0: g = i[3:0];
      2'd1: g = 4'(5 * i[3:0] + 1);
      2'd2: g = 4'(3 * i[3:0] + 5);
      default: g = 4'(7 * i[3:0]);
    endcase
    return g;
  endfunction

endpackage

FILE: rtl/mdk_front.sv
// ----------------------------------------------------------------------------
// mdk_front: seed registers and counter
// loads seeds, steps the 256-bit counter per request, hands the job onward
// ----------------------------------------------------------------------------
module mdk_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [mdk_pkg::IdxW:0]    cfg_idx_i,
  input  logic [63:0]               cfg_data_i,
  input  logic                      push_i,
  input  logic [63:0]               data_low_i,
  input  logic [63:0]               data_high_i,
  input  logic [4:0]                byte_count_i,
  output mdk_pkg::job_t             job_o
);

  logic [63:0] ctr_q [mdk_pkg::NumSeed];
  logic [255:0] cur, nxt;

  assign cur = {ctr_q[0], ctr_q[1], ctr_q[2], ctr_q[3]};
  assign nxt = cur + 256'd1;

  // counter update, seed write loads one word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) ctr_q[i] <= '0;
    end else if (cfg_we_i) begin
      if (!cfg_idx_i[mdk_pkg::IdxW]) ctr_q[cfg_idx_i[mdk_pkg::IdxW-1:0]] <= cfg_data_i;
    end else if (push_i) begin
      ctr_q[0] <= nxt[255:192];
      ctr_q[1] <= nxt[191:128];
      ctr_q[2] <= nxt[127:64];
      ctr_q[3] <= nxt[63:0];
    end
  end

  // classify byte count, saturating at sixteen
  always_comb begin
    job_o.counter   = nxt;
    job_o.data_low  = data_low_i;
    job_o.data_high = data_high_i;
    job_o.nbytes    = (byte_count_i > 5'(mdk_pkg::MaxBytes)) ? 5'(mdk_pkg::MaxBytes)
                                                            : byte_count_i;
  end

endmodule

FILE: rtl/mdk_fifo.sv
// ----------------------------------------------------------------------------
// mdk_fifo: small register queue
// two-entry first-in first-out store used between stages
// ----------------------------------------------------------------------------
module mdk_fifo #(
  parameter int unsigned Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             rd_i,
  output logic [Width-1:0] rdata_o,
  output logic             empty_o
);

  logic [Width-1:0] mem_q [2];
  logic wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign rdata_o = mem_q[rp_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (wr_i) wp_q <= ~wp_q;
      if (rd_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(wr_i) - 2'(rd_i);
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (wr_i) mem_q[wp_q] <= wdata_i;
  end

endmodule

FILE: rtl/mdk_back.sv
// ----------------------------------------------------------------------------
// mdk_back: iterative md5 core
// one round per cycle over the 32-byte counter message, then xor with data
// ----------------------------------------------------------------------------
module mdk_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           job_valid_i,
  input  mdk_pkg::job_t  job_i,
  output logic           job_take_o,
  output logic           res_valid_o,
  output mdk_pkg::res_t  res_o,
  input  logic           res_full_i
);

  logic              busy_q, done_q;
  logic [5:0]        rnd_q;
  logic [31:0]       a_q, b_q, c_q, d_q;
  logic [31:0]       m_q [8];
  logic [63:0]       dlo_q, dhi_q;
  logic [4:0]        nb_q;
  logic [31:0]       f, mg, sum, rot, nb_b;
  logic [3:0]        g;
  logic [4:0]        r;
  logic [127:0]      dig;
  logic [31:0]       ha, hb, hc, hd;

  // message word, counter bytes are big-endian into little-endian words
  always_comb begin
    g = mdk_pkg::round_g(rnd_q);
    case (g)
      4'd8:  mg = 32'h0000_0080;
      4'd14: mg = 32'h0000_0100;
      default: mg = g[3] ? 32'h0 : m_q[g[2:0]];
    endcase
  end

  // one md5 round
  always_comb begin
    case (rnd_q[5:4])
      2'd0: f = (b_q & c_q) | (~b_q & d_q);
      2'd1: f = (d_q & b_q) | (~d_q & c_q);
      2'd2: f = b_q ^ c_q ^ d_q;
      default: f = c_q ^ (b_q | ~d_q);
    endcase
    r    = mdk_pkg::round_rot(rnd_q);
    sum  = a_q + f + mdk_pkg::round_k(rnd_q) + mg;
    rot  = (sum << r) | (sum >> (6'd32 - {1'b0, r}));
    nb_b = b_q + rot;
  end

  assign job_take_o  = !busy_q && !done_q && job_valid_i;
  assign res_valid_o = done_q && !res_full_i;

  // round sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      rnd_q  <= '0;
    end else if (job_take_o) begin
      busy_q <= 1'b1;
      rnd_q  <= '0;
    end else if (busy_q) begin
      rnd_q <= rnd_q + 6'd1;
      if (rnd_q == 6'(mdk_pkg::NumRnd - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else if (res_valid_o) begin
      done_q <= 1'b0;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (job_take_o) begin
      a_q <= mdk_pkg::IvA; b_q <= mdk_pkg::IvB;
      c_q <= mdk_pkg::IvC; d_q <= mdk_pkg::IvD;
      for (int i = 0; i < 8; i++) begin
        m_q[i] <= {job_i.counter[255-32*i-24 -: 8], job_i.counter[255-32*i-16 -: 8],
                   job_i.counter[255-32*i-8 -: 8], job_i.counter[255-32*i -: 8]};
      end
      dlo_q <= job_i.data_low;
      dhi_q <= job_i.data_high;
      nb_q  <= job_i.nbytes;
    end else if (busy_q) begin
      a_q <= d_q; d_q <= c_q; c_q <= b_q; b_q <= nb_b;
    end
  end

  // final add and masked xor
  always_comb begin
    ha  = a_q + mdk_pkg::IvA;
    hb  = b_q + mdk_pkg::IvB;
    hc  = c_q + mdk_pkg::IvC;
    hd  = d_q + mdk_pkg::IvD;
    dig = {hd, hc, hb, ha};
    for (int i = 0; i < 16; i++) begin
      if (5'(i) < nb_q) dig[8*i +: 8] = dig[8*i +: 8] ^
        (i < 8 ? dlo_q[8*(i%8) +: 8] : dhi_q[8*(i%8) +: 8]);
    end
    res_o.out_low  = dig[63:0];
    res_o.out_high = dig[127:64];
  end

endmodule

FILE: rtl/md5_counter_keystream_xor.sv
// ----------------------------------------------------------------------------
// md5_counter_keystream_xor: md5 counter-mode keystream with data xor
// front counter stage, job queue, iterative md5 core, result queue
// ----------------------------------------------------------------------------
// Each request steps a 256-bit counter and gets one result: md5 of the counter
// bytes xored with the first byte_count data bytes. The md5 core runs one round
// per cycle. An accepted request waits in the job queue, is loaded into the
// core, runs the 64 rounds, and its result is then handed to the output queue.
// The core takes no new request until it has handed off the last result (load,
// 64 rounds, hand-off), and a full output queue holds that hand-off. The job
// queue accepts two requests back to back while the core is busy.
// Seed writes load the matching counter word and must happen while idle.
module md5_counter_keystream_xor (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i,
  input  logic        push,
  output logic        full,
  input  logic [63:0] data_low_i,
  input  logic [63:0] data_high_i,
  input  logic [4:0]  byte_count_i,
  output logic        empty,
  input  logic        pop,
  output logic [63:0] out_low_o,
  output logic [63:0] out_high_o
);

  mdk_pkg::job_t job, qjob;
  mdk_pkg::res_t res, qres;
  logic jempty, take, rvalid, rfull, acc;

  assign acc = push && !full;

  mdk_front u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .push_i(acc), .data_low_i, .data_high_i, .byte_count_i, .job_o(job)
  );

  mdk_fifo #(.Width($bits(mdk_pkg::job_t))) u_jobq (
    .clk_i, .rst_ni, .wr_i(acc), .wdata_i(job), .full_o(full),
    .rd_i(take), .rdata_o(qjob), .empty_o(jempty)
  );

  mdk_back u_back (
    .clk_i, .rst_ni, .job_valid_i(!jempty), .job_i(qjob), .job_take_o(take),
    .res_valid_o(rvalid), .res_o(res), .res_full_i(rfull)
  );

  mdk_fifo #(.Width($bits(mdk_pkg::res_t))) u_resq (
    .clk_i, .rst_ni, .wr_i(rvalid), .wdata_i(res), .full_o(rfull),
    .rd_i(pop && !empty), .rdata_o(qres), .empty_o(empty)
  );

  assign out_low_o  = qres.out_low;
  assign out_high_o = qres.out_high;

endmodule

FILE: test/testbench.sv
// ----------------------------------------------------------------------------
// md5 counter keystream testbench
// drives seed writes and xor requests, predicts each result with an md5 model
// of the 256-bit counter, and checks every popped result in order
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned SeedIdx0 = 0;
  localparam int unsigned SeedIdx3 = 3;
  localparam int unsigned BadIdx   = 4;
  localparam int unsigned Latency  = 80;
  localparam int unsigned WdLimit  = 2000;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [63:0] cfg_data_i;
  logic        push;
  logic        full;
  logic [63:0] data_low_i;
  logic [63:0] data_high_i;
  logic [4:0]  byte_count_i;
  logic        empty;
  logic        pop;
  logic [63:0] out_low_o;
  logic [63:0] out_high_o;

  // predictor state
  logic [255:0]  ctr_model;
  mdk_pkg::res_t expected_q[$];
  int            errors;
  int            idle_cycles;

  md5_counter_keystream_xor i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .push        (push),
    .full        (full),
    .data_low_i  (data_low_i),
    .data_high_i (data_high_i),
    .byte_count_i(byte_count_i),
    .empty       (empty),
    .pop         (pop),
    .out_low_o   (out_low_o),
    .out_high_o  (out_high_o)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // md5 tables
  function automatic logic [31:0] md5_sine(input int i);
    logic [31:0] t[64];
    t = '{32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee, 32'hf57c0faf,
          32'h4787c62a, 32'ha8304613, 32'hfd469501, 32'h698098d8, 32'h8b44f7af,
          32'hffff5bb1, 32'h895cd7be, 32'h6b901122, 32'hfd987193, 32'ha679438e,
          32'h49b40821, 32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
          32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8, 32'h21e1cde6,
          32'hc33707d6, 32'hf4d50d87, 32'h455a14ed, 32'ha9e3e905, 32'hfcefa3f8,
          32'h676f02d9, 32'h8d2a4c8a, 32'hfffa3942, 32'h8771f681, 32'h6d9d6122,
          32'hfde5380c, 32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
          32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05, 32'hd9d4d039,
          32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665, 32'hf4292244, 32'h432aff97,
          32'hab9423a7, 32'hfc93a039, 32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d,
          32'h85845dd1, 32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
          32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
    return t[i];
  endfunction

  // md5 digest of the 32 counter bytes, big-endian, as 16 bytes
  function automatic logic [127:0] counter_digest(input logic [255:0] c);
    logic [7:0]  blk[64];
    logic [31:0] m[16];
    logic [31:0] a, b, cc, d, f, t, s;
    int          rot[16];
    int          g, r;
    logic [31:0] h[4];
    logic [127:0] dg;
    rot = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};
    for (int i = 0; i < 64; i++) blk[i] = 8'h00;
    for (int i = 0; i < 32; i++) blk[i] = c[255 - 8*i -: 8];
    blk[32] = 8'h80;
    blk[57] = 8'h01;
    for (int i = 0; i < 16; i++)
      m[i] = {blk[4*i+3], blk[4*i+2], blk[4*i+1], blk[4*i]};
    a = 32'h67452301; b = 32'hefcdab89; cc = 32'h98badcfe; d = 32'h10325476;
    for (int i = 0; i < 64; i++) begin
      if (i < 16) begin
        f = (b & cc) | (~b & d); g = i;
      end else if (i < 32) begin
        f = (d & b) | (~d & cc); g = (5*i + 1) % 16;
      end else if (i < 48) begin
        f = b ^ cc ^ d; g = (3*i + 5) % 16;
      end else begin
        f = cc ^ (b | ~d); g = (7*i) % 16;
      end
      r = rot[(i/16)*4 + i%4];
      s = a + f + md5_sine(i) + m[g];
      t = d; d = cc; cc = b;
      b = b + ((s << r) | (s >> (32 - r)));
      a = t;
    end
    h[0] = a + 32'h67452301; h[1] = b + 32'hefcdab89;
    h[2] = cc + 32'h98badcfe; h[3] = d + 32'h10325476;
    // byte i in bits 8i+7:8i
    for (int i = 0; i < 16; i++) dg[8*i +: 8] = h[i/4][8*(i%4) +: 8];
    return dg;
  endfunction

  // steps the counter and returns the keystream xor data
  function automatic mdk_pkg::res_t keystream_xor(input logic [63:0] lo,
                                                  input logic [63:0] hi,
                                                  input logic [4:0] cnt);
    logic [127:0]  dg;
    logic [127:0]  dat;
    int            n;
    mdk_pkg::res_t rs;
    ctr_model = ctr_model + 256'd1;
    dg  = counter_digest(ctr_model);
    dat = {hi, lo};
    n   = (cnt > 16) ? 16 : cnt;
    for (int i = 0; i < 16; i++)
      if (i < n) dg[8*i +: 8] = dg[8*i +: 8] ^ dat[8*i +: 8];
    rs.out_low  = dg[63:0];
    rs.out_high = dg[127:64];
    return rs;
  endfunction

  // seed write, only while idle
  task automatic write_seed(input int idx, input logic [63:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= 3'(idx);
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx < mdk_pkg::NumSeed) ctr_model[255 - 64*idx -: 64] = val;
    @(negedge clk_i);
  endtask

  // sends one request after a random gap
  task automatic send_request(input logic [63:0] lo, input logic [63:0] hi,
                              input logic [4:0] cnt);
    int gap;
    gap = $urandom_range(0, 11);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    push         <= 1'b1;
    data_low_i   <= lo;
    data_high_i  <= hi;
    byte_count_i <= cnt;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    expected_q.push_back(keystream_xor(lo, hi, cnt));
    @(negedge clk_i);
  endtask

  task automatic drain_and_settle();
    push <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (Latency) @(negedge clk_i);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // byte count extremes, every odd count, and saturation above sixteen
  task automatic test_byte_counts();
    send_request('0, '0, 5'd0);
    send_request('1, '1, 5'd16);
    for (int c = 1; c < 32; c += 2) send_request(rand64(), rand64(), 5'(c));
    send_request('1, '1, 5'd31);
    send_request(rand64(), rand64(), 5'd17);
    drain_and_settle();
  endtask

  // all-ones counter wraps to zero; out-of-range index is ignored
  task automatic test_counter_wrap();
    for (int i = SeedIdx0; i <= SeedIdx3; i++) write_seed(i, '1);
    write_seed(BadIdx, 64'h0123_4567_89ab_cdef);
    write_seed(7, '0);
    send_request(rand64(), rand64(), 5'd8);
    send_request(rand64(), rand64(), 5'd4);
    drain_and_settle();
    // carry across one word boundary
    write_seed(2, 64'h0000_0000_0000_0005);
    write_seed(3, '1);
    send_request(rand64(), rand64(), 5'd16);
    send_request(rand64(), rand64(), 5'd0);
    drain_and_settle();
  endtask

  // random traffic under several seeds, one sender pause mid-phase
  task automatic test_random_traffic();
    for (int ph = 0; ph < 8; ph++) begin
      for (int i = SeedIdx0; i <= SeedIdx3; i++)
        if ($urandom_range(0, 2) != 0 || ph == 0) write_seed(i, rand64());
      if (ph == 7) write_seed(0, '0);
      for (int k = 0; k < 250; k++) begin
        if (ph == 3 && k == 100) begin
          push <= 1'b0;
          while (expected_q.size() != 0) @(negedge clk_i);
        end
        send_request(rand64(), rand64(), 5'($urandom_range(0, 31)));
      end
      drain_and_settle();
    end
  endtask

  // result checker with random stalls on pop
  initial begin : result_check
    mdk_pkg::res_t exp_r;
    int            stall;
    pop = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = $urandom_range(0, 11);
      if ($urandom_range(0, 3) == 0) stall = 0;
      if (stall != 0) begin
        pop <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      pop <= 1'b1;
      @(posedge clk_i);
      while (empty) @(posedge clk_i);
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result low %h high %h", $time, out_low_o, out_high_o);
        errors++;
      end else begin
        exp_r = expected_q.pop_front();
        if (out_low_o !== exp_r.out_low) begin
          $display("%0t: out_low expected %h actual %h", $time, exp_r.out_low, out_low_o);
          errors++;
        end
        if (out_high_o !== exp_r.out_high) begin
          $display("%0t: out_high expected %h actual %h", $time, exp_r.out_high,
                   out_high_o);
          errors++;
        end
      end
      @(negedge clk_i);
    end
  end

  // watchdog on cycles with no handshake
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty) || !rst_ni) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WdLimit) begin
      $display("md5_counter_keystream_xor regression: fail");
      $finish;
    end
  end

  initial begin
    errors       = 0;
    ctr_model    = '0;
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = '0;
    cfg_data_i   = '0;
    push         = 1'b0;
    data_low_i   = '0;
    data_high_i  = '0;
    byte_count_i = '0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_byte_counts();
    test_counter_wrap();
    test_random_traffic();
    if (errors == 0) begin
      $display("md5_counter_keystream_xor regression: pass");
    end else begin
      $display("md5_counter_keystream_xor regression: fail");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/mdk_pkg.sv
rtl/mdk_front.sv
rtl/mdk_fifo.sv
rtl/mdk_back.sv
rtl/md5_counter_keystream_xor.sv
test/testbench.sv
